FILE: hdl/swmm_pkg.sv
// Shared command and status types for the sliding-window min/max/mean core.
package swmm_pkg;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic accept;
    logic cfg_write;
    logic update;
    logic scan_step;
    logic div_load;
    logic div_step;
    logic publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_clear;
    logic need_scan;
    logic scan_done;
    logic div_last;
  } ctl_sts_t;

endpackage

FILE: hdl/swmm_sample_if.sv
// Input item channel: push or clear command with one sample.
interface swmm_sample_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

FILE: hdl/swmm_result_if.sv
// Result item channel: count, sum, mean, min and max of the window.
interface swmm_result_if #(
  parameter int CNT_W       = 7,
  parameter int SUM_W       = 38,
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic        [CNT_W-1:0]       count;
  logic signed [SUM_W-1:0]       window_sum;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_max;

  modport source (output valid, output count, output window_sum, output mean,
                  output window_min, output window_max, input ready);
  modport sink   (input valid, input count, input window_sum, input mean,
                  input window_min, input window_max, output ready);
endinterface

FILE: hdl/swmm_cfg_if.sv
// Configuration write channel carrying the window length.
interface swmm_cfg_if #(
  parameter int CNT_W = 7
);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/swmm_datapath.sv
// Datapath: sample ring memory, window statistics, rescan unit and serial divider.
module swmm_datapath #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32,
  parameter int ADDR_W      = $clog2(MAX_WINDOW),
  parameter int CNT_W       = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W       = SAMPLE_BITS + ADDR_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swmm_pkg::ctl_cmd_t            cmd,
  output swmm_pkg::ctl_sts_t            sts,
  input  logic                          in_kind,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic        [CNT_W-1:0]       cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic        [CNT_W-1:0]       out_count,
  output logic signed [SUM_W-1:0]       out_sum,
  output logic signed [SAMPLE_BITS-1:0] out_mean,
  output logic signed [SAMPLE_BITS-1:0] out_min,
  output logic signed [SAMPLE_BITS-1:0] out_max
);

  localparam int W1     = CNT_W + 1;
  localparam int DIV_CW = $clog2(SUM_W);

  logic        [CNT_W-1:0]       len_eff;
  logic        [ADDR_W-1:0]      oldest_pos;
  logic        [CNT_W-1:0]       held_count;
  logic signed [SUM_W-1:0]       running_sum;
  logic        [ADDR_W-1:0]      min_pos;
  logic        [ADDR_W-1:0]      max_pos;
  logic signed [SAMPLE_BITS-1:0] min_val;
  logic signed [SAMPLE_BITS-1:0] max_val;
  logic                          item_kind;
  logic signed [SAMPLE_BITS-1:0] item_sample;
  logic                          lost_max;
  logic                          lost_min;
  logic        [ADDR_W-1:0]      scan_addr;
  logic        [CNT_W-1:0]       scan_cnt;
  logic                          scan_first;
  logic                          tag_valid;
  logic        [ADDR_W-1:0]      tag_pos;
  logic        [SUM_W-1:0]       dq;
  logic        [CNT_W-1:0]       rem;
  logic        [DIV_CW-1:0]      div_cnt;
  logic                          div_neg;

  logic        [SAMPLE_BITS-1:0] sample_mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic        [ADDR_W-1:0]      rd_addr;
  logic                          mem_we;
  logic        [ADDR_W-1:0]      mem_waddr;

  logic                          is_full;
  logic        [W1-1:0]          push_sum_w;
  logic        [ADDR_W-1:0]      push_pos;
  logic        [W1-1:0]          oldest_inc_w;
  logic        [ADDR_W-1:0]      oldest_inc;
  logic        [W1-1:0]          scan_inc_w;
  logic        [ADDR_W-1:0]      scan_inc;
  logic                          fv_ge_max;
  logic                          fv_le_min;
  logic                          lost_max_c;
  logic                          lost_min_c;
  logic signed [SUM_W-1:0]       fv_ext;
  logic signed [SUM_W-1:0]       old_ext;
  logic        [SUM_W-1:0]       abs_sum;
  logic        [W1-1:0]          rem_sh;
  logic        [W1-1:0]          rem_sub;
  logic                          div_ge;
  logic        [SUM_W-1:0]       quot_signed;

  always_comb begin
    is_full      = (held_count == len_eff);
    push_sum_w   = W1'(oldest_pos) + W1'(held_count);
    push_pos     = (push_sum_w >= W1'(len_eff)) ? ADDR_W'(push_sum_w - W1'(len_eff))
                                                : ADDR_W'(push_sum_w);
    oldest_inc_w = W1'(oldest_pos) + W1'(1);
    oldest_inc   = (oldest_inc_w == W1'(len_eff)) ? '0 : ADDR_W'(oldest_inc_w);
    scan_inc_w   = W1'(scan_addr) + W1'(1);
    scan_inc     = (scan_inc_w == W1'(len_eff)) ? '0 : ADDR_W'(scan_inc_w);
    fv_ge_max    = (item_sample >= max_val);
    fv_le_min    = (item_sample <= min_val);
    lost_max_c   = is_full && !fv_ge_max && (max_pos == oldest_pos);
    lost_min_c   = is_full && !fv_le_min && (min_pos == oldest_pos);
    fv_ext       = {{(SUM_W-SAMPLE_BITS){item_sample[SAMPLE_BITS-1]}}, item_sample};
    old_ext      = {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
    abs_sum      = running_sum[SUM_W-1] ? (SUM_W'(0) - running_sum) : running_sum;
    rem_sh       = {rem, dq[SUM_W-1]};
    rem_sub      = rem_sh - W1'(held_count);
    div_ge       = (rem_sh >= W1'(held_count));
    quot_signed  = div_neg ? (SUM_W'(0) - dq) : dq;
    mem_we       = cmd.update && (item_kind == swmm_pkg::KIND_PUSH);
    mem_waddr    = is_full ? oldest_pos : push_pos;
    rd_addr      = cmd.scan_step ? scan_addr : oldest_pos;
  end

  always_comb begin
    sts.out_free  = !out_valid || out_ready;
    sts.is_clear  = (item_kind == swmm_pkg::KIND_CLEAR);
    sts.need_scan = (item_kind == swmm_pkg::KIND_PUSH) && (lost_max_c || lost_min_c);
    sts.scan_done = (scan_cnt == held_count) && !tag_valid;
    sts.div_last  = (div_cnt == DIV_CW'(SUM_W - 1));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[mem_waddr] <= item_sample;
    end
    rd_data <= sample_mem[rd_addr];
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      len_eff     <= CNT_W'(MAX_WINDOW);
      oldest_pos  <= '0;
      held_count  <= '0;
      running_sum <= '0;
      min_pos     <= '0;
      max_pos     <= '0;
      tag_valid   <= 1'b0;
      scan_cnt    <= '0;
    end else if (cmd.cfg_write) begin
      if (cfg_data == '0) begin
        len_eff <= CNT_W'(1);
      end else if (cfg_data > CNT_W'(MAX_WINDOW)) begin
        len_eff <= CNT_W'(MAX_WINDOW);
      end else begin
        len_eff <= cfg_data;
      end
      oldest_pos  <= '0;
      held_count  <= '0;
      running_sum <= '0;
      min_pos     <= '0;
      max_pos     <= '0;
    end else if (cmd.update) begin
      tag_valid  <= 1'b0;
      scan_cnt   <= '0;
      scan_first <= 1'b1;
      scan_addr  <= oldest_inc;
      lost_max   <= lost_max_c;
      lost_min   <= lost_min_c;
      if (item_kind == swmm_pkg::KIND_CLEAR) begin
        oldest_pos  <= '0;
        held_count  <= '0;
        running_sum <= '0;
        min_pos     <= '0;
        max_pos     <= '0;
      end else if (!is_full) begin
        held_count <= held_count + CNT_W'(1);
        if (held_count == '0) begin
          running_sum <= fv_ext;
          min_pos     <= push_pos;
          max_pos     <= push_pos;
          min_val     <= item_sample;
          max_val     <= item_sample;
        end else begin
          running_sum <= running_sum + fv_ext;
          if (fv_ge_max) begin
            max_pos <= push_pos;
            max_val <= item_sample;
          end
          if (fv_le_min) begin
            min_pos <= push_pos;
            min_val <= item_sample;
          end
        end
      end else begin
        running_sum <= running_sum - old_ext + fv_ext;
        oldest_pos  <= oldest_inc;
        if (fv_ge_max) begin
          max_pos <= oldest_pos;
          max_val <= item_sample;
        end
        if (fv_le_min) begin
          min_pos <= oldest_pos;
          min_val <= item_sample;
        end
      end
    end else if (cmd.scan_step) begin
      if (scan_cnt != held_count) begin
        scan_cnt  <= scan_cnt + CNT_W'(1);
        scan_addr <= scan_inc;
        tag_pos   <= scan_addr;
        tag_valid <= 1'b1;
      end else begin
        tag_valid <= 1'b0;
      end
      if (tag_valid) begin
        scan_first <= 1'b0;
        if (lost_max && (scan_first || rd_data >= max_val)) begin
          max_val <= rd_data;
          max_pos <= tag_pos;
        end
        if (lost_min && (scan_first || rd_data <= min_val)) begin
          min_val <= rd_data;
          min_pos <= tag_pos;
        end
      end
    end
  end

  // item latch and restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind   <= in_kind;
      item_sample <= in_sample;
    end
    if (cmd.div_load) begin
      dq      <= abs_sum;
      rem     <= '0;
      div_cnt <= '0;
      div_neg <= running_sum[SUM_W-1];
    end else if (cmd.div_step) begin
      dq      <= {dq[SUM_W-2:0], div_ge};
      rem     <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      div_cnt <= div_cnt + DIV_CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_count <= held_count;
      out_sum   <= running_sum;
      if (held_count == '0) begin
        out_mean <= '0;
        out_min  <= '0;
        out_max  <= '0;
      end else begin
        out_mean <= quot_signed[SAMPLE_BITS-1:0];
        out_min  <= min_val;
        out_max  <= max_val;
      end
    end
  end

  a_held_le_len: assert property (@(posedge clk) disable iff (rst)
    held_count <= len_eff)
    else $error("held count exceeds window length");

  a_oldest_in_ring: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(oldest_pos) < len_eff)
    else $error("oldest position outside the ring");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> scan_cnt <= held_count)
    else $error("rescan issued past held entries");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (held_count != '0 && !cmd.scan_step && !cmd.update && !cmd.accept
     && !$past(cmd.cfg_write) && !$past(rst)) |-> min_val <= max_val)
    else $error("window min above window max");

endmodule

FILE: hdl/swmm_ctrl.sv
// Controller: sequences accept, update, rescan, divide and publish for each item.
module swmm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  output swmm_pkg::ctl_cmd_t cmd,
  input  swmm_pkg::ctl_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DIV_LOAD,
    S_DIVIDE,
    S_PUBLISH
  } state_t;

  state_t state;

  always_comb begin
    in_ready      = (state == S_IDLE) && !cfg_valid;
    cfg_ready     = (state == S_IDLE);
    cmd.accept    = in_ready && in_valid;
    cmd.cfg_write = cfg_ready && cfg_valid;
    cmd.update    = (state == S_EXEC);
    cmd.scan_step = (state == S_SCAN);
    cmd.div_load  = (state == S_DIV_LOAD);
    cmd.div_step  = (state == S_DIVIDE);
    cmd.publish   = (state == S_PUBLISH) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (sts.is_clear) begin
            state <= S_PUBLISH;
          end else if (sts.need_scan) begin
            state <= S_SCAN;
          end else begin
            state <= S_DIV_LOAD;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state <= S_DIV_LOAD;
          end
        end
        S_DIV_LOAD: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (sts.div_last) begin
            state <= S_PUBLISH;
          end
        end
        S_PUBLISH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.update, cmd.scan_step, cmd.div_load, cmd.div_step,
              cmd.publish}))
    else $error("more than one datapath command at once");

  a_accept_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_EXEC)
    else $error("accepted item not executed");

  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.cfg_write |-> !cmd.accept)
    else $error("config write and item accepted together");

endmodule

FILE: hdl/sliding_window_min_max_mean_core.sv
// Top level of the sliding-window minimum, maximum and mean core.
// Usage: items enter on "samples" (kind 0 pushes sample, kind 1 empties the
// window); one result item per input leaves on "results" with count, sum,
// mean (truncated toward zero), minimum and maximum of the held samples.
// "cfg" writes the window length (0 acts as 1, above MAX_WINDOW as
// MAX_WINDOW); every write also empties the window.
// A clear goes from the update step straight to publishing. A push goes
// through the update, a rescan of the ring when the evicted sample was the
// window extreme (over the single read port of the sample memory), the
// divider load, the serial divide (one quotient bit per cycle) and publish.
// One item is in work at a time; the next can be taken from the cycle after its
// predecessor's result is loaded into the output register.
// Reset empties the window and sets the length to MAX_WINDOW.
// If results.ready stays low, the result waits in the output register and
// the next item is worked on, but holds before publishing until it drains.
module sliding_window_min_max_mean_core #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  swmm_sample_if.sink          samples,
  swmm_cfg_if.sink             cfg,
  swmm_result_if.source        results
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + ADDR_W;

  swmm_pkg::ctl_cmd_t cmd;
  swmm_pkg::ctl_sts_t sts;

  swmm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  swmm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (samples.kind),
    .in_sample (samples.sample),
    .cfg_data  (cfg.data),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_count (results.count),
    .out_sum   (results.window_sum),
    .out_mean  (results.mean),
    .out_min   (results.window_min),
    .out_max   (results.window_max)
  );

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the sliding-window min/max/mean core: directed and random items.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0]         count;
    logic signed [37:0] window_sum;
    logic signed [31:0] mean;
    logic signed [31:0] window_min;
    logic signed [31:0] window_max;
  } window_stats_t;

  typedef enum int {STYLE_WIDE, STYLE_NARROW, STYLE_RISING, STYLE_FALLING, STYLE_EXTREME}
    sample_style_t;

  class window_scoreboard_t;
    logic signed [31:0] ring [64];
    int unsigned        oldest, held, lo_pos, hi_pos;
    logic [6:0]         length_reg;
    logic signed [37:0] total;
    window_stats_t      expected_q [$];
    int                 errors, inputs_noted, clears_noted, results_checked, rescans;

    function new();
      length_reg = 7'd64;
      clear_window();
    endfunction

    function void clear_window();
      oldest = 0;
      held   = 0;
      total  = '0;
      lo_pos = 0;
      hi_pos = 0;
    endfunction

    function int unsigned span();
      if (length_reg == 0) return 1;
      if (length_reg > 64) return 64;
      return length_reg;
    endfunction

    function void set_length(logic [6:0] v);
      length_reg = v;
      clear_window();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // walk held entries oldest first; later equal values take the position
    function void rescan(int unsigned len, bit want_hi);
      int unsigned best, p;
      best = oldest % len;
      for (int unsigned i = 1; i < held; i++) begin
        p = (oldest + i) % len;
        if (want_hi ? (ring[p] >= ring[best]) : (ring[p] <= ring[best])) best = p;
      end
      if (want_hi) hi_pos = best;
      else lo_pos = best;
      rescans++;
    endfunction

    function void note_input(logic kind, logic signed [31:0] s);
      int unsigned   len, pos, old;
      bit            new_hi, new_lo, lost_hi, lost_lo;
      window_stats_t e;
      len = span();
      inputs_noted++;
      if (kind == swmm_pkg::KIND_CLEAR) begin
        clear_window();
        clears_noted++;
      end else if (held < len) begin
        pos = (oldest + held) % len;
        if (held == 0) begin
          lo_pos = pos;
          hi_pos = pos;
          total  = '0;
        end else begin
          if (s >= ring[hi_pos % len]) hi_pos = pos;
          if (s <= ring[lo_pos % len]) lo_pos = pos;
        end
        ring[pos] = s;
        total = total + s;
        held++;
      end else begin
        old     = oldest % len;
        new_hi  = s >= ring[hi_pos % len];
        new_lo  = s <= ring[lo_pos % len];
        lost_hi = !new_hi && (hi_pos % len) == old;
        lost_lo = !new_lo && (lo_pos % len) == old;
        total = total - ring[old] + s;
        ring[old] = s;
        oldest = (old + 1) % len;
        if (new_hi) hi_pos = old;
        if (new_lo) lo_pos = old;
        if (lost_hi) rescan(len, 1'b1);
        if (lost_lo) rescan(len, 1'b0);
      end
      e.count      = 7'(held);
      e.window_sum = total;
      if (held == 0) begin
        e.mean       = '0;
        e.window_min = '0;
        e.window_max = '0;
      end else begin
        e.mean       = 32'(longint'(total) / longint'(held));
        e.window_min = ring[lo_pos % len];
        e.window_max = ring[hi_pos % len];
      end
      expected_q.push_back(e);
    endfunction

    function void check_field(string what, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
      end
    endfunction

    function void check_result(window_stats_t got);
      window_stats_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none got count %0d",
                 $time, got.count);
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      check_field("count", want.count, got.count);
      check_field("window_sum", want.window_sum, got.window_sum);
      check_field("mean", want.mean, got.mean);
      check_field("window_min", want.window_min, got.window_min);
      check_field("window_max", want.window_max, got.window_max);
    endfunction
  endclass

  logic clk;
  logic rst;

  swmm_sample_if #(.SAMPLE_BITS(32))                      sample_ch ();
  swmm_cfg_if    #(.CNT_W(7))                             cfg_ch ();
  swmm_result_if #(.CNT_W(7), .SUM_W(38), .SAMPLE_BITS(32)) result_ch ();

  sliding_window_min_max_mean_core #(
    .MAX_WINDOW (64),
    .SAMPLE_BITS(32)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_ch),
    .cfg    (cfg_ch),
    .results(result_ch)
  );

  window_scoreboard_t sb = new();
  bit                 steady;
  logic signed [31:0] trend;
  int                 lengths_used;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready)
      sb.note_input(sample_ch.kind, sample_ch.sample);
    if (!rst && cfg_ch.valid && cfg_ch.ready)
      sb.set_length(cfg_ch.data);
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result('{result_ch.count, result_ch.window_sum, result_ch.mean,
                        result_ch.window_min, result_ch.window_max});
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_sample(sample_style_t style);
    case (style)
      STYLE_NARROW:  return 32'($urandom_range(0, 16)) - 32'd8;
      STYLE_RISING: begin
        trend = trend + 32'($urandom_range(0, 32'h0002_0000));
        return trend;
      end
      STYLE_FALLING: begin
        trend = trend - 32'($urandom_range(0, 32'h0002_0000));
        return trend;
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:       return $urandom();
    endcase
  endfunction

  // leaves valid high after the accepting edge; a later call with a gap, or drain, lowers it
  task automatic send_item(logic k, logic [31:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.kind   <= k;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  task automatic push(logic [31:0] s);
    send_item(swmm_pkg::KIND_PUSH, s);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_length(logic [6:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    lengths_used++;
  endtask

  // result side: ready runs of random length broken by stalls
  initial begin
    int run, stall;
    result_ch.ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      result_ch.ready <= 1'b1;
      run = $urandom_range(1, 30);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int            lengths [14];
    int            eff, n, clear_pct;
    logic          k;
    sample_style_t style;

    lengths = '{1, 2, 3, 5, 8, 16, 64, 0, 127, 65, 4, 33, 2, 64};
    rst              <= 1'b1;
    sample_ch.valid  <= 1'b0;
    sample_ch.kind   <= swmm_pkg::KIND_PUSH;
    sample_ch.sample <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    steady = 1'b0;
    trend  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default length: field extremes, clear, clear of an empty window
    push(32'h7FFF_FFFF);
    push(32'h8000_0000);
    push(32'h0000_0000);
    push(32'hFFFF_FFFF);
    send_item(swmm_pkg::KIND_CLEAR, 32'hA5A5_A5A5);
    send_item(swmm_pkg::KIND_CLEAR, 32'h5A5A_5A5A);
    push(32'h0001_0000);

    // length 3: eviction of the max, ties, full-scale sums
    write_length(7'd3);
    push(32'h0005_0000);
    push(32'h0002_0000);
    push(32'h0003_0000);
    push(32'h0004_0000);
    push(32'h0001_0000);
    push(32'h0005_0000);
    push(32'h0005_0000);
    push(32'h0005_0000);
    push(32'hFFFF_0000);
    push(32'h8000_0000);
    push(32'h8000_0000);
    push(32'h8000_0000);
    push(32'h7FFF_FFFF);
    push(32'h7FFF_FFFF);
    push(32'h7FFF_FFFF);
    send_item(swmm_pkg::KIND_CLEAR, 32'h0000_0000);

    foreach (lengths[p]) begin
      write_length(7'(lengths[p]));
      eff = (lengths[p] == 0) ? 1 : (lengths[p] > 64 ? 64 : lengths[p]);
      n = (eff <= 8) ? 50 : 100;
      steady = (p % 4 == 2);
      clear_pct = (p % 3 == 0) ? 0 : $urandom_range(1, 5);
      style = sample_style_t'($urandom_range(0, 4));
      trend = $urandom();
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 6) style = sample_style_t'($urandom_range(0, 4));
        if (p == 3 && i == n / 2) drain();
        k = ($urandom_range(0, 99) < clear_pct) ? swmm_pkg::KIND_CLEAR : swmm_pkg::KIND_PUSH;
        send_item(k, pick_sample(style));
      end
    end
    steady = 1'b0;

    drain();
    repeat (120) @(posedge clk);
    $display("Run covered %0d items (%0d clears) over %0d window length writes.",
             sb.inputs_noted, sb.clears_noted, lengths_used);
    $display("Checked %0d results; extreme evictions forced %0d rescans.",
             sb.results_checked, sb.rescans);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
